FILE: hdl/arm_pkg.sv
// Package for the accumulator RAM machine executor: request/result structs,
// operation, mode, status and action codes, controller states. No dependencies.
`default_nettype none
package arm_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_STORE = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_READ  = 4'd6,
    OP_WRITE = 4'd7,
    OP_JUMP  = 4'd8,
    OP_JZERO = 4'd9,
    OP_JGTZ  = 4'd10,
    OP_HALT  = 4'd11
  } op_t;

  localparam logic [1:0] MODE_CONST    = 2'd0;
  localparam logic [1:0] MODE_DIRECT   = 2'd1;
  localparam logic [1:0] MODE_INDIRECT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_MODE    = 2'd3;

  localparam logic [1:0] ACT_NEXT   = 2'd0;
  localparam logic [1:0] ACT_BRANCH = 2'd1;
  localparam logic [1:0] ACT_HALT   = 2'd2;

  typedef struct packed {
    logic [3:0]        operation;
    logic [1:0]        mode;
    logic signed [31:0] operand;
    logic [9:0]        jump_target;
    logic signed [31:0] read_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        next_action;
    logic [9:0]        branch_address;
    logic              out_valid;
    logic signed [31:0] out_value;
    logic signed [31:0] accumulator;
    logic [1:0]        status;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_RD_PTR,
    S_CHK_PTR,
    S_RD_VAL,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIV_FIN,
    S_STORE,
    S_DONE
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic rd_ptr;
    logic rd_val;
    logic exec;
    logic mul_done;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic wr_mem;
    logic emit;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clr_last;
    logic op_needs_fetch;
    logic op_needs_dest;
    logic op_mul;
    logic op_div;
    logic mode_bad;
    logic opnd_bad;
    logic ptr_bad;
    logic mode_indirect;
    logic divisor_zero;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/arm_ctrl.sv
// Controller state machine for the accumulator RAM machine executor.
// Depends on arm_pkg; drives arm_dp through cmd_t and reads stat_t.
`default_nettype none
module arm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  arm_pkg::stat_t      st,
  output arm_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                err_mode,
  output logic                err_range
);

  arm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= arm_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arm_pkg::S_CLEAR:   if (st.clr_last) state_nxt = arm_pkg::S_IDLE;
      arm_pkg::S_IDLE:    if (start) state_nxt = arm_pkg::S_DECODE;
      arm_pkg::S_DECODE: begin
        if (st.mode_bad || st.opnd_bad) state_nxt = arm_pkg::S_DONE;
        else if (st.op_needs_fetch || st.op_needs_dest) begin
          if (st.mode_indirect) state_nxt = arm_pkg::S_RD_PTR;
          else if (st.op_needs_fetch) state_nxt = arm_pkg::S_RD_VAL;
          else state_nxt = arm_pkg::S_STORE;
        end else if (st.op_needs_fetch) state_nxt = arm_pkg::S_EXEC;
        else state_nxt = arm_pkg::S_EXEC;
      end
      arm_pkg::S_RD_PTR:  state_nxt = arm_pkg::S_CHK_PTR;
      arm_pkg::S_CHK_PTR: begin
        if (st.ptr_bad) state_nxt = arm_pkg::S_DONE;
        else if (st.op_needs_fetch) state_nxt = arm_pkg::S_RD_VAL;
        else state_nxt = arm_pkg::S_STORE;
      end
      arm_pkg::S_RD_VAL:  state_nxt = arm_pkg::S_EXEC;
      arm_pkg::S_EXEC: begin
        if (st.op_mul) state_nxt = arm_pkg::S_MUL;
        else if (st.op_div && !st.divisor_zero) state_nxt = arm_pkg::S_DIV;
        else state_nxt = arm_pkg::S_DONE;
      end
      arm_pkg::S_MUL:     state_nxt = arm_pkg::S_DONE;
      arm_pkg::S_DIV:     if (st.div_last) state_nxt = arm_pkg::S_DIV_FIN;
      arm_pkg::S_DIV_FIN: state_nxt = arm_pkg::S_DONE;
      arm_pkg::S_STORE:   state_nxt = arm_pkg::S_DONE;
      arm_pkg::S_DONE:    state_nxt = arm_pkg::S_IDLE;
      default:            state_nxt = arm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    err_mode  = 1'b0;
    err_range = 1'b0;
    case (state_r)
      arm_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
      arm_pkg::S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      arm_pkg::S_DECODE: begin
        err_mode  = st.mode_bad;
        err_range = !st.mode_bad && st.opnd_bad;
        cmd.rd_ptr = 1'b1;
        cmd.rd_val = !st.mode_indirect;
      end
      arm_pkg::S_CHK_PTR: begin
        err_range  = st.ptr_bad;
        cmd.rd_val = 1'b1;
      end
      arm_pkg::S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = st.op_div;
      end
      arm_pkg::S_MUL:     cmd.mul_done = 1'b1;
      arm_pkg::S_DIV:     cmd.div_step = 1'b1;
      arm_pkg::S_DIV_FIN: cmd.div_fin = 1'b1;
      arm_pkg::S_STORE:   cmd.wr_mem = 1'b1;
      arm_pkg::S_DONE:    cmd.emit = 1'b1;
      default:            cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/arm_dp.sv
// Datapath for the accumulator RAM machine executor: data memory, accumulator,
// multiplier stage, radix-2 divider, result register. Depends on arm_pkg.
`default_nettype none
module arm_dp #(
  parameter int unsigned DATA_DEPTH    = 256,
  parameter int unsigned PROGRAM_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  arm_pkg::in_req_t in_req,
  input  arm_pkg::cmd_t    cmd,
  input  wire logic        err_mode,
  input  wire logic        err_range,
  output arm_pkg::stat_t   st,
  output logic             out_strobe,
  output arm_pkg::out_res_t out_res
);

  localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  logic [31:0] mem [DATA_DEPTH];
  logic [31:0] rd_data_r;

  arm_pkg::in_req_t req_r;
  logic [31:0] acc_r, acc_nxt;
  logic [AW:0] clr_cnt_r;
  logic [AW-1:0] addr_r;
  logic [1:0]  status_r;
  logic [1:0]  action_r;
  logic [9:0]  baddr_r;
  logic        ovalid_r;
  logic [31:0] oval_r;
  logic [31:0] prod_r;
  logic [31:0] dvd_r, dvs_r, rem_r, quo_r;
  logic [5:0]  div_cnt_r;
  logic        q_neg_r;
  logic        strobe_r;

  function automatic logic addr_ok(input logic [31:0] a);
    addr_ok = !a[31] && ({1'b0, a} < 33'(DATA_DEPTH));
  endfunction

  logic [3:0]  op;
  logic [1:0]  mode;
  logic [31:0] val;
  logic        take;
  logic [32:0] rem_sh;

  assign op   = req_r.operation;
  assign mode = req_r.mode;
  assign val  = (mode == arm_pkg::MODE_CONST) ? req_r.operand : rd_data_r;

  always_comb begin
    st = '0;
    st.clr_last = (clr_cnt_r == (AW+1)'(DATA_DEPTH - 1));
    st.op_needs_fetch = (op == arm_pkg::OP_LOAD) || (op == arm_pkg::OP_ADD) ||
      (op == arm_pkg::OP_SUB) || (op == arm_pkg::OP_MUL) ||
      (op == arm_pkg::OP_DIV) || (op == arm_pkg::OP_WRITE);
    st.op_needs_dest = (op == arm_pkg::OP_STORE) || (op == arm_pkg::OP_READ);
    st.op_mul = (op == arm_pkg::OP_MUL);
    st.op_div = (op == arm_pkg::OP_DIV);
    st.mode_bad = (op > arm_pkg::OP_HALT) ||
      (st.op_needs_fetch && (mode == 2'd3)) ||
      (st.op_needs_dest && (mode != arm_pkg::MODE_DIRECT) &&
       (mode != arm_pkg::MODE_INDIRECT));
    st.opnd_bad = (st.op_needs_fetch || st.op_needs_dest) &&
      (mode != arm_pkg::MODE_CONST) && !addr_ok(req_r.operand);
    st.ptr_bad = !addr_ok(rd_data_r);
    st.mode_indirect = (mode == arm_pkg::MODE_INDIRECT);
    st.divisor_zero = (val == 32'd0);
    st.div_last = (div_cnt_r == 6'd31);
  end

  always_comb begin
    case (op)
      arm_pkg::OP_JUMP:  take = 1'b1;
      arm_pkg::OP_JZERO: take = (acc_r == 32'd0);
      arm_pkg::OP_JGTZ:  take = (acc_r != 32'd0) && !acc_r[31];
      default:           take = 1'b0;
    endcase
  end

  assign rem_sh = {rem_r, dvd_r[31]};

  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_cnt_r[AW-1:0]] <= 32'd0;
    else if (cmd.wr_mem) mem[addr_r] <= (op == arm_pkg::OP_STORE) ? acc_r : req_r.read_value;
    else if (cmd.exec && st.op_needs_fetch && (op != arm_pkg::OP_WRITE) &&
             !st.op_mul && !st.op_div)
      mem[0] <= acc_nxt;
    else if (cmd.mul_done) mem[0] <= prod_r;
    else if (cmd.div_fin) mem[0] <= q_neg_r ? (32'd0 - quo_r) : quo_r;
    if (cmd.rd_ptr) rd_data_r <= mem[req_r.operand[AW-1:0]];
    else if (cmd.rd_val) rd_data_r <= mem[rd_data_r[AW-1:0]];
  end

  always_comb begin
    case (op)
      arm_pkg::OP_ADD: acc_nxt = acc_r + val;
      arm_pkg::OP_SUB: acc_nxt = acc_r - val;
      default:         acc_nxt = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      acc_r     <= '0;
      strobe_r  <= 1'b0;
      status_r  <= arm_pkg::ST_OK;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + (AW+1)'(1);
      if (cmd.latch) begin
        req_r    <= in_req;
        status_r <= arm_pkg::ST_OK;
        action_r <= arm_pkg::ACT_NEXT;
        baddr_r  <= '0;
        ovalid_r <= 1'b0;
        oval_r   <= '0;
      end
      if (err_mode)  status_r <= arm_pkg::ST_MODE;
      if (err_range) status_r <= arm_pkg::ST_RANGE;
      if (cmd.rd_ptr && !st.mode_indirect) addr_r <= req_r.operand[AW-1:0];
      else if (cmd.rd_val && st.mode_indirect) addr_r <= rd_data_r[AW-1:0];
      if (cmd.exec) begin
        if (op == arm_pkg::OP_HALT) action_r <= arm_pkg::ACT_HALT;
        else if (take) begin
          if ({22'd0, req_r.jump_target} < 32'(PROGRAM_DEPTH)) begin
            action_r <= arm_pkg::ACT_BRANCH;
            baddr_r  <= req_r.jump_target;
          end else status_r <= arm_pkg::ST_RANGE;
        end else if (op == arm_pkg::OP_WRITE) begin
          ovalid_r <= 1'b1;
          oval_r   <= val;
        end else if (st.op_div && st.divisor_zero) status_r <= arm_pkg::ST_DIVZERO;
        else if (st.op_needs_fetch && !st.op_mul && !st.op_div) acc_r <= acc_nxt;
        prod_r <= acc_r * val;
      end
      if (cmd.div_start) begin
        dvd_r     <= acc_r[31] ? (32'd0 - acc_r) : acc_r;
        dvs_r     <= val[31] ? (32'd0 - val) : val;
        q_neg_r   <= acc_r[31] ^ val[31];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 6'd1;
        dvd_r     <= {dvd_r[30:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= 32'(rem_sh - {1'b0, dvs_r});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      if (cmd.mul_done) acc_r <= prod_r;
      if (cmd.div_fin)  acc_r <= q_neg_r ? (32'd0 - quo_r) : quo_r;
      if (cmd.wr_mem && (addr_r == '0))
        acc_r <= (op == arm_pkg::OP_STORE) ? acc_r : req_r.read_value;
    end
  end

  assign out_strobe = strobe_r;
  always_comb begin
    out_res.next_action    = action_r;
    out_res.branch_address = baddr_r;
    out_res.out_valid      = ovalid_r;
    out_res.out_value      = oval_r;
    out_res.accumulator    = acc_r;
    out_res.status         = status_r;
  end

`ifndef SYNTHESIS
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_res.status != arm_pkg::ST_OK) |->
      (out_res.next_action == arm_pkg::ACT_NEXT) && !out_res.out_valid)
    else $error("error result with action");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("strobe held");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (div_cnt_r == 6'd0))
    else $error("divider not reset");
`endif

endmodule
`default_nettype wire

FILE: hdl/accumulator_ram_machine_executor.sv
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: synchronous rst_n starts a clearing pass over the data memory, busy during
// it. The receiver cannot stall; out_strobe marks one cycle.
// Top level: instantiates arm_ctrl and arm_dp; depends on arm_pkg.
`default_nettype none
module accumulator_ram_machine_executor #(
  parameter int unsigned DATA_DEPTH    = 256,
  parameter int unsigned PROGRAM_DEPTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  arm_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output arm_pkg::out_res_t out_res
);

  arm_pkg::cmd_t  cmd;
  arm_pkg::stat_t st;
  logic err_mode, err_range;

  arm_ctrl u_ctrl (
    .clk, .rst_n, .start, .st, .cmd, .busy, .err_mode, .err_range
  );

  arm_dp #(.DATA_DEPTH(DATA_DEPTH), .PROGRAM_DEPTH(PROGRAM_DEPTH)) u_dp (
    .clk, .rst_n, .in_req, .cmd, .err_mode, .err_range, .st, .out_strobe, .out_res
  );

endmodule
`default_nettype wire
